// File: src/tdfe_pkg.sv
// Shared types and constants for the table-driven state machine engine.
// No dependencies; imported by the controller, the datapath and the top level.
package tdfe_pkg;

  localparam int EntryCountW = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [3:0]  entry_index;
    logic [7:0]  entry_from_state;
    logic [7:0]  entry_event;
    logic [7:0]  entry_to_state;
    logic        entry_has_action;
    logic [7:0]  event_id;
    logic        action_ok;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic        transitioned;
    logic [7:0]  present_state;
    logic [31:0] change_time_ms;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic advance;
    logic take;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic limit_zero;
  } dp_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } ctl_state_e;

endpackage

// File: src/tdfe_ctrl.sv
// Sequencing controller: accepts a transaction, walks the table scan, raises the strobe.
// Depends on tdfe_pkg for the command/status structs and the state encoding.
module tdfe_ctrl import tdfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    command_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.load    = (command_i == CMD_LOAD);
          if (command_i == CMD_EVENT && !sts_i.limit_zero) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.hit) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DONE;
        end else if (sts_i.last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_FETCH;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

// File: src/tdfe_datapath.sv
// Datapath: transition table memory, scan index, machine state, change time, result.
// Depends on tdfe_pkg for the payload structs and the command/status structs.
module tdfe_datapath import tdfe_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int STATE_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  input  in_item_t               item_i,
  input  logic                   cfg_we_i,
  input  logic [EntryCountW-1:0] cfg_wdata_i,
  output dp_sts_t                sts_o,
  output out_item_t              result_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LimW = IdxW + 1;
  localparam int EntW = 2 * STATE_BITS + 9;

  logic [EntW-1:0]        mem_q [TABLE_DEPTH];
  logic [EntW-1:0]        rd_q;
  logic [EntryCountW-1:0] entry_count_q;
  logic [IdxW-1:0]        idx_q;
  logic [STATE_BITS-1:0]  cur_state_q;
  logic [31:0]            time_q;
  logic                   matched_q;
  logic                   trans_q;
  logic [7:0]             ev_q;
  logic                   ok_q;
  logic [31:0]            now_q;

  logic [IdxW+3:0]        slot_ext;
  logic [IdxW-1:0]        wr_addr;
  logic                   slot_ok;
  logic [STATE_BITS+7:0]  from_ext;
  logic [STATE_BITS+7:0]  to_ext;
  logic [EntW-1:0]        wr_entry;
  logic [LimW-1:0]        limit;
  logic [LimW-1:0]        next_pos;
  logic [STATE_BITS-1:0]  rd_from;
  logic [7:0]             rd_event;
  logic [STATE_BITS-1:0]  rd_to;
  logic                   rd_action;
  logic [STATE_BITS+7:0]  cur_ext;

  assign slot_ext = {{IdxW{1'b0}}, item_i.entry_index};
  assign wr_addr  = slot_ext[IdxW-1:0];
  assign slot_ok  = (32'(item_i.entry_index) < TABLE_DEPTH);
  assign from_ext = {{STATE_BITS{1'b0}}, item_i.entry_from_state};
  assign to_ext   = {{STATE_BITS{1'b0}}, item_i.entry_to_state};
  assign wr_entry = {item_i.entry_has_action, to_ext[STATE_BITS-1:0],
                     item_i.entry_event, from_ext[STATE_BITS-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      mem_q[wr_addr] <= wr_entry;
    end
    rd_q <= mem_q[idx_q];
  end

  assign {rd_action, rd_to, rd_event, rd_from} = rd_q;

  always_comb begin
    if (32'(entry_count_q) > TABLE_DEPTH) begin
      limit = LimW'(TABLE_DEPTH);
    end else begin
      limit = LimW'(entry_count_q);
    end
  end

  assign next_pos = LimW'({1'b0, idx_q}) + LimW'(1);

  assign sts_o.hit        = (rd_from == cur_state_q) && (rd_event == ev_q);
  assign sts_o.last       = (next_pos >= limit);
  assign sts_o.limit_zero = (limit == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      idx_q         <= '0;
      cur_state_q   <= '0;
      time_q        <= '0;
      matched_q     <= 1'b0;
      trans_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        idx_q     <= '0;
        matched_q <= 1'b0;
        trans_q   <= 1'b0;
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.take) begin
        matched_q <= 1'b1;
        if (rd_action && ok_q) begin
          cur_state_q <= rd_to;
          time_q      <= now_q;
          trans_q     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ev_q  <= item_i.event_id;
      ok_q  <= item_i.action_ok;
      now_q <= item_i.now_ms;
    end
  end

  assign cur_ext = {8'b0, cur_state_q};

  assign result_o.matched        = matched_q;
  assign result_o.transitioned   = trans_q;
  assign result_o.present_state  = cur_ext[7:0];
  assign result_o.change_time_ms = time_q;

endmodule

// File: src/table_driven_fsm_engine_top.sv
// Top level of the table-driven state machine engine: controller plus datapath.
// Depends on tdfe_pkg, tdfe_ctrl and tdfe_datapath.
//
// A transaction is taken when start is high and busy is low; each one yields
// exactly one result, shown on result_o for the single cycle that done_o is high,
// and the receiver cannot stall it. A load transaction, or an event with an entry
// count of zero, strobes its result in the cycle after acceptance. An event scans
// the table one entry at a time through the registered memory read, a fetch
// state then a check state per entry, and stops at the first match or at the end
// of the counted entries (the entry count, capped at the table depth); its result
// strobes in the done state that follows. No clearing pass follows reset; entries
// must be loaded before they are searched.
module table_driven_fsm_engine_top import tdfe_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int STATE_BITS  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  in_item_t               item_i,
  output logic                   busy,
  output logic                   done_o,
  output out_item_t              result_o,
  input  logic                   cfg_we_i,
  input  logic [EntryCountW-1:0] cfg_wdata_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tdfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .command_i(item_i.command),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  tdfe_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .STATE_BITS (STATE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sts_o      (dp_sts),
    .result_o   (result_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CMD_LOAD) |=> done_o)
    else $error("load transaction did not strobe its result next cycle");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  a_no_flags_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && item_i.command == CMD_LOAD))
      |-> (!result_o.matched && !result_o.transitioned))
    else $error("load transaction reported a match or transition");

endmodule
